// ----- src/icyd_pkg.sv -----
// ----------------------------------------------------------------------------
// icyd_pkg
// Shared constants, codes and control structs for the ICY metadata demux.
// ----------------------------------------------------------------------------
`default_nettype none

package icyd_pkg;

  // default sizes
  localparam int META_LIMIT_DEF = 1024;
  localparam int TITLE_MAX_DEF  = 64;

  // fixed field widths
  localparam int ITV_W   = 24;
  localparam int BLEFT_W = 12;
  localparam int MATCH_W = 4;
  localparam int PAT_LEN = 13;

  // result kinds
  localparam logic [1:0] KIND_AUDIO = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // special characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // scan unit command word
  typedef struct packed {
    logic       clear;
    logic       scan;
    logic       cont;
    logic       fin;
    logic       trim_dec;
    logic [7:0] data;
  } scan_cmd_t;

  // scan unit status
  typedef struct packed {
    logic found;
    logic stopped;
    logic need_second;
  } scan_stat_t;

  // title pattern StreamTitle='
  function automatic logic [7:0] pat_char(input logic [MATCH_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h53; // S
      4'd1:    c = 8'h74; // t
      4'd2:    c = 8'h72; // r
      4'd3:    c = 8'h65; // e
      4'd4:    c = 8'h61; // a
      4'd5:    c = 8'h6D; // m
      4'd6:    c = 8'h54; // T
      4'd7:    c = 8'h69; // i
      4'd8:    c = 8'h74; // t
      4'd9:    c = 8'h6C; // l
      4'd10:   c = 8'h65; // e
      4'd11:   c = 8'h3D; // =
      4'd12:   c = 8'h27; // quote
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- src/icyd_in_if.sv -----
// ----------------------------------------------------------------------------
// icyd_in_if
// Stream byte channel: valid/ready with command and data byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface icyd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- src/icyd_out_if.sv -----
// ----------------------------------------------------------------------------
// icyd_out_if
// Result channel: valid/ready with kind, value and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface icyd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

`default_nettype wire

// ----- src/icyd_title_ram.sv -----
// ----------------------------------------------------------------------------
// icyd_title_ram
// Title character store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module icyd_title_ram #(
  parameter int DEPTH = 63,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/icyd_scan.sv -----
// ----------------------------------------------------------------------------
// icyd_scan
// Title scan unit: pattern match, title append with quote handling, trim.
// ----------------------------------------------------------------------------
`default_nettype none

module icyd_scan #(
  parameter int TITLE_MAX = 64,
  parameter int LW        = 6,
  parameter int AW        = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire icyd_pkg::scan_cmd_t cmd,
  output icyd_pkg::scan_stat_t  stat,
  output logic      [LW-1:0]    title_len,
  output logic                  we,
  output logic      [AW-1:0]    waddr,
  output logic      [7:0]       wdata
);
  import icyd_pkg::*;

  localparam logic [LW-1:0] LEN_CAP = LW'(TITLE_MAX - 1);

  logic [MATCH_W-1:0] match_pos, match_pos_next;
  logic               found, found_next;
  logic               quote_pending, quote_pending_next;
  logic               closed, closed_next;
  logic               stopped, stopped_next;
  logic [LW-1:0]      len_next;
  logic [7:0]         held, held_next;
  logic               app_en;
  logic [7:0]         app_char;
  logic               need_second;
  logic [LW-1:0]      len_inc;

  assign len_inc = title_len + 1'b1;

  // decide what this cycle does
  always_comb begin
    match_pos_next     = match_pos;
    found_next         = found;
    quote_pending_next = quote_pending;
    closed_next        = closed;
    stopped_next       = stopped;
    held_next          = held;
    app_en             = 1'b0;
    app_char           = cmd.data;
    need_second        = 1'b0;
    if (cmd.clear) begin
      match_pos_next     = '0;
      found_next         = 1'b0;
      quote_pending_next = 1'b0;
      closed_next        = 1'b0;
      stopped_next       = 1'b0;
    end else if (cmd.scan) begin
      if (cmd.data == CH_NUL) begin
        stopped_next = 1'b1;
      end else if (found) begin
        if (!closed) begin
          if (quote_pending) begin
            quote_pending_next = 1'b0;
            if (cmd.data == CH_SEMI) begin
              closed_next = 1'b1;
            end else begin
              // held quote goes in first, the byte is handled next cycle if room remains
              app_en      = 1'b1;
              app_char    = CH_QUOTE;
              need_second = (len_inc < LEN_CAP);
              held_next   = cmd.data;
            end
          end else if (cmd.data == CH_QUOTE) begin
            quote_pending_next = 1'b1;
          end else begin
            app_en = 1'b1;
          end
        end
      end else begin
        if (match_pos < MATCH_W'(PAT_LEN) && cmd.data == pat_char(match_pos)) begin
          match_pos_next = match_pos + 1'b1;
        end else begin
          match_pos_next = (cmd.data == pat_char('0)) ? MATCH_W'(1) : '0;
        end
        if (match_pos_next >= MATCH_W'(PAT_LEN)) begin
          found_next = 1'b1;
        end
      end
    end else if (cmd.cont) begin
      if (held == CH_QUOTE) begin
        quote_pending_next = 1'b1;
      end else begin
        app_en   = 1'b1;
        app_char = held;
      end
    end else if (cmd.fin) begin
      if (found && quote_pending && !closed) begin
        app_en   = 1'b1;
        app_char = CH_QUOTE;
      end
      quote_pending_next = 1'b0;
    end
  end

  // append and length update
  always_comb begin
    len_next = title_len;
    we       = 1'b0;
    waddr    = title_len[AW-1:0];
    wdata    = app_char;
    if (cmd.clear || (cmd.scan && !found && found_next)) begin
      len_next = '0;
    end else if (app_en) begin
      if (title_len < LEN_CAP) begin
        we       = 1'b1;
        len_next = len_inc;
      end
    end else if (cmd.trim_dec) begin
      len_next = title_len - 1'b1;
    end
  end

  // scan state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_pos     <= '0;
      found         <= 1'b0;
      quote_pending <= 1'b0;
      closed        <= 1'b0;
      stopped       <= 1'b0;
      title_len     <= '0;
    end else begin
      match_pos     <= match_pos_next;
      found         <= found_next;
      quote_pending <= quote_pending_next;
      stopped       <= stopped_next;
      title_len     <= len_next;
      closed        <= closed_next || (app_en && len_next >= LEN_CAP);
    end
  end

  // byte held over for the follow-up append in ST_SCAN2
  always_ff @(posedge clk) begin
    held <= held_next;
  end

  assign stat.found       = found;
  assign stat.stopped     = stopped;
  assign stat.need_second = need_second;

endmodule

`default_nettype wire

// ----- src/icy_metadata_demux_top.sv -----
// ----------------------------------------------------------------------------
// icy_metadata_demux_top
// Splits a stream body into audio bytes and ICY title characters.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  stream    in   valid/ready   cmd, data_byte
//  result    out  valid/ready   kind, value, last
//  cfg       in   cfg_we        cfg_data (metadata interval)
//
//  audio, length and most block bytes are taken in the idle state whenever
//  the output register is free; the output register takes a new byte while
//  the previous result is being taken. a block byte whose held quote and own
//  byte both go to the store also passes ST_SCAN2. block end: finish, trim of
//  trailing spaces, title characters, then the marker, plus any output stall.
//  reset is synchronous; the title store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module icy_metadata_demux_top #(
  parameter int META_LIMIT = icyd_pkg::META_LIMIT_DEF,
  parameter int TITLE_MAX  = icyd_pkg::TITLE_MAX_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [icyd_pkg::ITV_W-1:0] cfg_data,
  icyd_in_if.sink                       stream,
  icyd_out_if.source                    result
);
  import icyd_pkg::*;

  localparam int PW    = $clog2(META_LIMIT + 1);
  localparam int LW    = $clog2(TITLE_MAX);
  localparam int DEPTH = TITLE_MAX - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] POS_SCAN_END = PW'(META_LIMIT - 1);
  localparam logic [PW-1:0] POS_MAX      = PW'(META_LIMIT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN2 = 3'd1;
  localparam logic [2:0] ST_FIN   = 3'd2;
  localparam logic [2:0] ST_TRIM  = 3'd3;
  localparam logic [2:0] ST_TRIMW = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;
  localparam logic [2:0] ST_EMITW = 3'd6;
  localparam logic [2:0] ST_MARK  = 3'd7;

  logic [2:0]         state, state_next;
  logic [ITV_W-1:0]   interval;
  logic [ITV_W-1:0]   audio_left, audio_left_next;
  logic               in_block, in_block_next;
  logic [BLEFT_W-1:0] block_left, block_left_next;
  logic [PW-1:0]      block_pos, block_pos_next;
  logic               fin_after, fin_after_next;
  logic [LW-1:0]      idx, idx_next;

  logic               ov;
  logic               load;
  logic [1:0]         load_kind;
  logic [7:0]         load_value;
  logic               load_last;
  logic               out_free;
  logic               accept;

  scan_cmd_t          scmd;
  scan_stat_t         sstat;
  logic [LW-1:0]      title_len;
  logic [LW-1:0]      len_m1;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [7:0]         wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [7:0]         rdata;
  logic [BLEFT_W-1:0] left_dec;

  assign out_free     = !ov || result.ready;
  assign stream.ready = (state == ST_IDLE) && out_free;
  assign accept       = stream.valid && stream.ready;
  assign len_m1       = title_len - 1'b1;
  assign left_dec     = (block_left != '0) ? block_left - 1'b1 : block_left;

  // sequencer
  always_comb begin
    state_next      = state;
    audio_left_next = audio_left;
    in_block_next   = in_block;
    block_left_next = block_left;
    block_pos_next  = block_pos;
    fin_after_next  = fin_after;
    idx_next        = idx;
    load            = 1'b0;
    load_kind       = KIND_AUDIO;
    load_value      = stream.data_byte;
    load_last       = 1'b1;
    scmd            = '0;
    scmd.data       = stream.data_byte;
    re              = 1'b0;
    raddr           = idx[AW-1:0];
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (stream.cmd) begin
            scmd.clear      = 1'b1;
            in_block_next   = 1'b0;
            block_left_next = '0;
            block_pos_next  = '0;
            audio_left_next = interval;
          end else if (interval == '0) begin
            load = 1'b1;
          end else if (in_block) begin
            scmd.scan = (block_pos < POS_SCAN_END) && !sstat.stopped;
            if (block_pos < POS_MAX) begin
              block_pos_next = block_pos + 1'b1;
            end
            block_left_next = left_dec;
            fin_after_next  = (left_dec == '0);
            if (scmd.scan && sstat.need_second) begin
              state_next = ST_SCAN2;
            end else if (left_dec == '0) begin
              state_next = ST_FIN;
            end
          end else if (audio_left != '0) begin
            load            = 1'b1;
            audio_left_next = audio_left - 1'b1;
          end else begin
            // length byte
            scmd.clear     = 1'b1;
            block_pos_next = '0;
            if (stream.data_byte == 8'd0) begin
              in_block_next   = 1'b0;
              block_left_next = '0;
              audio_left_next = interval;
            end else begin
              in_block_next   = 1'b1;
              block_left_next = {stream.data_byte, 4'd0};
            end
          end
        end
      end
      ST_SCAN2: begin
        scmd.cont  = 1'b1;
        state_next = fin_after ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (sstat.found) begin
          scmd.fin   = 1'b1;
          state_next = ST_TRIM;
        end else begin
          scmd.clear      = 1'b1;
          in_block_next   = 1'b0;
          block_left_next = '0;
          block_pos_next  = '0;
          audio_left_next = interval;
          state_next      = ST_IDLE;
        end
      end
      ST_TRIM: begin
        if (title_len == '0) begin
          idx_next   = '0;
          state_next = ST_EMIT;
        end else begin
          re         = 1'b1;
          raddr      = len_m1[AW-1:0];
          state_next = ST_TRIMW;
        end
      end
      ST_TRIMW: begin
        if (rdata == CH_SPACE) begin
          scmd.trim_dec = 1'b1;
          state_next    = ST_TRIM;
        end else begin
          idx_next   = '0;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (idx == title_len) begin
          state_next = ST_MARK;
        end else begin
          re         = 1'b1;
          state_next = ST_EMITW;
        end
      end
      ST_EMITW: begin
        if (out_free) begin
          load       = 1'b1;
          load_kind  = KIND_CHAR;
          load_value = rdata;
          load_last  = 1'b0;
          idx_next   = idx + 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_MARK: begin
        if (out_free) begin
          load            = 1'b1;
          load_kind       = KIND_DONE;
          load_value      = 8'd0;
          scmd.clear      = 1'b1;
          in_block_next   = 1'b0;
          block_left_next = '0;
          block_pos_next  = '0;
          audio_left_next = interval;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      interval   <= '0;
      audio_left <= '0;
      in_block   <= 1'b0;
      block_left <= '0;
      block_pos  <= '0;
      fin_after  <= 1'b0;
      idx        <= '0;
      ov         <= 1'b0;
    end else begin
      state      <= state_next;
      audio_left <= audio_left_next;
      in_block   <= in_block_next;
      block_left <= block_left_next;
      block_pos  <= block_pos_next;
      fin_after  <= fin_after_next;
      idx        <= idx_next;
      if (cfg_we) begin
        interval <= cfg_data;
      end
      if (load) begin
        ov <= 1'b1;
      end else if (result.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (load) begin
      result.kind  <= load_kind;
      result.value <= load_value;
      result.last  <= load_last;
    end
  end

  assign result.valid = ov;

  icyd_scan #(
    .TITLE_MAX (TITLE_MAX),
    .LW        (LW),
    .AW        (AW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cmd       (scmd),
    .stat      (sstat),
    .title_len (title_len),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata)
  );

  icyd_title_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ----- tb/sv/icy_metadata_demux_top_tb.sv -----
// ----------------------------------------------------------------------------
// icy_metadata_demux_top_tb
// Self-checking bench for the ICY metadata demux. A short table of directed
// words comes first, then phases of random stream traffic. Most of that
// traffic is well-formed: audio runs, length bytes and metadata blocks that
// carry titles of many shapes. The rest is noise: random bytes, random short
// lengths and start commands in the middle of a block. Every accepted stream
// word is run through a bit-accurate demux predictor, and every result word
// is compared in order against the predicted words. The interval register
// is rewritten between phases, only after all due words have drained.
// ----------------------------------------------------------------------------
`default_nettype none

module icy_metadata_demux_top_tb;
  import icyd_pkg::*;

  localparam int META_LIMIT    = META_LIMIT_DEF;
  localparam int TITLE_MAX     = TITLE_MAX_DEF;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_WORDS  = 500;
  localparam logic [8*PAT_LEN-1:0] TITLE_KEY = "StreamTitle='";

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } icy_word_t;

  typedef enum int {OP_BYTE, OP_START, OP_CFG} row_op_t;
  typedef enum int {PACE_FULL, PACE_TX_IDLE, PACE_RX_STALL, PACE_BOTH} pace_t;

  typedef struct {
    row_op_t     op;
    logic [23:0] arg;
    bit          has_gold;
    icy_word_t   gold;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [ITV_W-1:0] cfg_data;

  icyd_in_if  stream_if ();
  icyd_out_if result_if ();

  icy_metadata_demux_top #(
    .META_LIMIT(META_LIMIT),
    .TITLE_MAX (TITLE_MAX)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .stream  (stream_if),
    .result  (result_if)
  );

  // demux predictor state
  logic [ITV_W-1:0]   itv_reg;
  logic [ITV_W-1:0]   aud_left;
  logic               blk_active;
  logic [BLEFT_W-1:0] blk_left;
  logic [10:0]        blk_pos;
  logic               scan_halt;
  logic [MATCH_W-1:0] pat_idx;
  logic               ttl_found;
  logic               quote_held;
  logic               ttl_closed;
  logic [7:0]         ttl_buf [64];
  logic [5:0]         ttl_len;

  icy_word_t split_words [$];
  icy_word_t due_words [$];
  logic [7:0] meta_q [$];
  dir_row_t dir_rows [$];
  icy_word_t no_gold;
  icy_word_t got_w;
  icy_word_t want_w;

  int tx_idle_pct;
  int rx_stall_pct;
  int err_count;
  int words_sent;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #(12 * 600000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] key_char(input logic [MATCH_W-1:0] idx);
    return TITLE_KEY[8*(PAT_LEN-1-int'(idx)) +: 8];
  endfunction

  function automatic void clear_blk();
    blk_active = 1'b0;
    blk_left   = '0;
    blk_pos    = '0;
    scan_halt  = 1'b0;
    pat_idx    = '0;
    ttl_found  = 1'b0;
    quote_held = 1'b0;
    ttl_closed = 1'b0;
    ttl_len    = '0;
  endfunction

  function automatic void ttl_append(input logic [7:0] c);
    if (ttl_len < TITLE_MAX - 1) begin
      ttl_buf[ttl_len] = c;
      ttl_len++;
    end
    if (ttl_len >= TITLE_MAX - 1) ttl_closed = 1'b1;
  endfunction

  function automatic void emit(input logic [1:0] k, input logic [7:0] v);
    icy_word_t w;
    w.kind  = k;
    w.value = v;
    w.last  = 1'b0;
    split_words.push_back(w);
  endfunction

  // predict the result words of one stream word
  function automatic void split_byte(input logic c, input logic [7:0] b);
    bit        skip;
    int        i;
    icy_word_t w;
    split_words.delete();
    if (c) begin
      clear_blk();
      aud_left = itv_reg;
    end else if (itv_reg == 0) begin
      emit(KIND_AUDIO, b);
    end else if (blk_active) begin
      // title scan over the searched region
      if (blk_pos < META_LIMIT - 1 && !scan_halt) begin
        if (b == CH_NUL) begin
          scan_halt = 1'b1;
        end else if (ttl_found) begin
          if (!ttl_closed) begin
            skip = 1'b0;
            if (quote_held) begin
              quote_held = 1'b0;
              if (b == CH_SEMI) begin
                ttl_closed = 1'b1;
                skip = 1'b1;
              end else begin
                ttl_append(CH_QUOTE);
                if (ttl_closed) skip = 1'b1;
              end
            end
            if (!skip) begin
              if (b == CH_QUOTE) quote_held = 1'b1;
              else ttl_append(b);
            end
          end
        end else begin
          if (pat_idx < PAT_LEN && b == key_char(pat_idx)) pat_idx++;
          else pat_idx = (b == key_char('0)) ? 4'd1 : 4'd0;
          if (pat_idx >= PAT_LEN) begin
            ttl_found = 1'b1;
            ttl_len = '0;
          end
        end
      end
      if (blk_pos < META_LIMIT) blk_pos++;
      if (blk_left > 0) blk_left--;
      // block end: if a title was found, close a held quote, trim, emit title and marker
      if (blk_left == 0) begin
        if (ttl_found) begin
          if (quote_held && !ttl_closed) ttl_append(CH_QUOTE);
          quote_held = 1'b0;
          while (ttl_len > 0 && ttl_buf[ttl_len - 6'd1] == CH_SPACE) ttl_len--;
          for (i = 0; i < ttl_len; i++) emit(KIND_CHAR, ttl_buf[6'(i)]);
          emit(KIND_DONE, 8'h00);
        end
        clear_blk();
        aud_left = itv_reg;
      end
    end else if (aud_left > 0) begin
      emit(KIND_AUDIO, b);
      aud_left--;
    end else begin
      // length byte
      clear_blk();
      if (b == 0) begin
        aud_left = itv_reg;
      end else begin
        blk_active = 1'b1;
        blk_left = {b, 4'b0000};
      end
    end
    if (split_words.size() > 0) begin
      w = split_words.pop_back();
      w.last = 1'b1;
      split_words.push_back(w);
    end
  endfunction

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_FULL: begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      PACE_TX_IDLE: begin
        tx_idle_pct = 69;
        rx_stall_pct = 0;
      end
      PACE_RX_STALL: begin
        tx_idle_pct = 0;
        rx_stall_pct = 69;
      end
      default: begin
        tx_idle_pct = 9;
        rx_stall_pct = 9;
      end
    endcase
  endtask

  // send one stream word and record the words it makes due
  task automatic put_word(input logic c, input logic [7:0] d, input bit has_gold,
                          input icy_word_t gold_w);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
    stream_if.valid     <= 1'b1;
    stream_if.cmd       <= c;
    stream_if.data_byte <= d;
    do @(posedge clk); while (stream_if.ready !== 1'b1);
    if (c) meta_q.delete();
    split_byte(c, d);
    if (has_gold) due_words.push_back(gold_w);
    else foreach (split_words[i]) due_words.push_back(split_words[i]);
    words_sent++;
  endtask

  // wait until every due word is out, then let the block settle
  task automatic drain_results();
    stream_if.valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [ITV_W-1:0] v);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    itv_reg = v;
  endtask

  function automatic void add_row(input row_op_t op, input logic [23:0] arg,
                                  input bit has_gold, input logic [1:0] k,
                                  input logic [7:0] v);
    dir_row_t r;
    r.op            = op;
    r.arg           = arg;
    r.has_gold      = has_gold;
    r.gold.kind     = k;
    r.gold.value    = v;
    r.gold.last     = 1'b1;
    dir_rows.push_back(r);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) meta_q.push_back(s[i]);
  endfunction

  // mostly printable, sometimes any nonzero byte
  function automatic logic [7:0] text_char();
    if ($urandom_range(9, 0) == 0) return 8'($urandom_range(255, 1));
    return 8'($urandom_range(8'h7E, 8'h20));
  endfunction

  function automatic void push_chars(input int n);
    for (int i = 0; i < n; i++) meta_q.push_back(text_char());
  endfunction

  function automatic void push_letters(input int n);
    for (int i = 0; i < n; i++) meta_q.push_back(8'h61 + 8'($urandom_range(25, 0)));
  endfunction

  // fill one metadata block and pick its length byte
  task automatic build_meta(input bit big, output logic [7:0] len_byte);
    int  variant;
    int  total;
    bit  pad_zero;
    meta_q.delete();
    if (big) begin
      // pattern close to the end of the searched region, title cut by it
      push_letters(1000);
      push_text("StreamTitle='");
      push_letters(70);
      push_text("';");
    end else begin
      variant = $urandom_range(9, 0);
      push_chars($urandom_range(8, 0));
      if (variant == 8) push_text("StreamTitSStreamTitle='");
      else if (variant != 0) push_text("StreamTitle='");
      case (variant)
        0: push_chars($urandom_range(40, 5));
        2: push_chars($urandom_range(30, 1));
        3: begin
          push_letters($urandom_range(10, 1));
          repeat ($urandom_range(5, 1)) meta_q.push_back(CH_SPACE);
        end
        4: begin
          push_letters($urandom_range(6, 1));
          meta_q.push_back(CH_QUOTE);
          push_letters($urandom_range(6, 0));
        end
        5: push_letters($urandom_range(80, 60));
        6: begin
          push_letters($urandom_range(8, 1));
          meta_q.push_back(CH_QUOTE);
        end
        7: begin
          push_letters(2);
          meta_q.push_back(CH_NUL);
          push_letters(2);
        end
        8: push_chars($urandom_range(10, 1));
        9: repeat ($urandom_range(6, 1)) meta_q.push_back(CH_SPACE);
        default: ;
      endcase
      if (variant != 0 && variant != 6) push_text("';");
      if ($urandom_range(9, 0) < 3) push_text("StreamUrl='x';");
    end
    total = ((meta_q.size() + 15) / 16) * 16;
    if (!big && $urandom_range(4, 0) == 0) total += 16;
    pad_zero = 1'($urandom_range(1, 0));
    while (meta_q.size() < total)
      meta_q.push_back(pad_zero ? 8'h00 : 8'($urandom_range(255, 0)));
    len_byte = 8'(total / 16);
  endtask

  // one random stream word, shaped by where the demux stands
  task automatic gen_step();
    logic [7:0] b;
    logic [7:0] lb;
    int         roll;
    roll = $urandom_range(99, 0);
    if (roll == 0) begin
      put_word(1'b1, 8'($urandom_range(255, 0)), 1'b0, no_gold);
    end else if (itv_reg != 0 && !blk_active && aud_left == 0) begin
      if (roll < 6) begin
        meta_q.delete();
        lb = 8'($urandom_range(3, 0));
      end else if (roll < 11) begin
        meta_q.delete();
        lb = 8'h00;
      end else begin
        build_meta(1'b0, lb);
      end
      put_word(1'b0, lb, 1'b0, no_gold);
    end else if (itv_reg != 0 && blk_active && meta_q.size() > 0) begin
      b = meta_q.pop_front();
      if (roll < 8) b = 8'($urandom_range(255, 0));
      put_word(1'b0, b, 1'b0, no_gold);
    end else begin
      put_word(1'b0, 8'($urandom_range(255, 0)), 1'b0, no_gold);
    end
  endtask

  // result sink: random stalls and in-order compare
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        got_w.kind  = result_if.kind;
        got_w.value = result_if.value;
        got_w.last  = result_if.last;
        if (due_words.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected word: kind=%0d value=%02h last=%0b",
                     got_w.kind, got_w.value, got_w.last);
        end else begin
          want_w = due_words.pop_front();
          if (got_w.kind !== want_w.kind || got_w.value !== want_w.value ||
              got_w.last !== want_w.last) begin
            err_count++;
            // fields shown as kind/value/last
            if (err_count <= 10)
              $display("word mismatch: expected %0d/%02h/%0b, got %0d/%02h/%0b",
                       want_w.kind, want_w.value, want_w.last,
                       got_w.kind, got_w.value, got_w.last);
          end
        end
      end
      result_if.ready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // stimulus
  initial begin
    string      key_row;
    logic [7:0] lb;
    int         phase;
    int         n_dir;
    logic [ITV_W-1:0] itv;

    stream_if.valid     <= 1'b0;
    stream_if.cmd       <= 1'b0;
    stream_if.data_byte <= 8'h00;
    cfg_we              <= 1'b0;
    cfg_data            <= '0;
    rst                 <= 1'b1;
    no_gold      = '0;
    err_count    = 0;
    words_sent   = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    itv_reg  = '0;
    aud_left = '0;
    for (int i = 0; i < 64; i++) ttl_buf[6'(i)] = 8'h00;
    clear_blk();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table: pass-through extremes, start, length right after a
    // register write, an empty title, zero length, then the widest interval
    add_row(OP_BYTE, 24'h00, 1'b1, KIND_AUDIO, 8'h00);
    add_row(OP_BYTE, 24'hFF, 1'b1, KIND_AUDIO, 8'hFF);
    add_row(OP_START, 24'h00, 1'b0, KIND_AUDIO, 8'h00);
    add_row(OP_BYTE, 24'hA5, 1'b1, KIND_AUDIO, 8'hA5);
    add_row(OP_CFG, 24'd2, 1'b0, KIND_AUDIO, 8'h00);
    add_row(OP_BYTE, 24'h01, 1'b0, KIND_AUDIO, 8'h00);
    key_row = "StreamTitle='';";
    for (int i = 0; i < key_row.len(); i++)
      add_row(OP_BYTE, 24'(key_row[i]), 1'b0, KIND_AUDIO, 8'h00);
    add_row(OP_BYTE, 24'h00, 1'b0, KIND_AUDIO, 8'h00);
    add_row(OP_BYTE, 24'h5A, 1'b1, KIND_AUDIO, 8'h5A);
    add_row(OP_BYTE, 24'hC3, 1'b1, KIND_AUDIO, 8'hC3);
    add_row(OP_BYTE, 24'h00, 1'b0, KIND_AUDIO, 8'h00);
    add_row(OP_BYTE, 24'h7E, 1'b1, KIND_AUDIO, 8'h7E);
    add_row(OP_CFG, 24'hFFFFFF, 1'b0, KIND_AUDIO, 8'h00);
    add_row(OP_START, 24'h00, 1'b0, KIND_AUDIO, 8'h00);
    add_row(OP_BYTE, 24'h81, 1'b1, KIND_AUDIO, 8'h81);

    set_pace(PACE_BOTH);
    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        OP_CFG:   write_interval(dir_rows[i].arg);
        OP_START: put_word(1'b1, 8'h00, 1'b0, no_gold);
        default:  put_word(1'b0, dir_rows[i].arg[7:0], dir_rows[i].has_gold,
                           dir_rows[i].gold);
      endcase
    end
    n_dir = words_sent;

    // random phases over several interval settings and pacing modes
    phase = 0;
    while (words_sent < n_dir + RANDOM_WORDS || phase < 8) begin
      case (phase % 6)
        0: itv = '0;
        1: itv = 24'hFFFFFF;
        2: itv = 24'd1;
        3: itv = ITV_W'($urandom_range(40, 2));
        4: itv = ITV_W'($urandom_range(300, 41));
        default: itv = 24'd16;
      endcase
      write_interval(itv);
      set_pace(pace_t'(phase % 4));
      if ($urandom_range(99, 0) < 70)
        put_word(1'b1, 8'($urandom_range(255, 0)), 1'b0, no_gold);
      repeat ($urandom_range(90, 40)) gen_step();
      phase++;
    end

    // one block longer than the searched region
    write_interval(24'd4);
    set_pace(PACE_FULL);
    put_word(1'b1, 8'h00, 1'b0, no_gold);
    repeat (4) put_word(1'b0, 8'($urandom_range(255, 0)), 1'b0, no_gold);
    build_meta(1'b1, lb);
    put_word(1'b0, lb, 1'b0, no_gold);
    while (meta_q.size() > 0) put_word(1'b0, meta_q.pop_front(), 1'b0, no_gold);
    put_word(1'b0, 8'($urandom_range(255, 0)), 1'b0, no_gold);

    drain_results();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
